### hw/rtl/mltl_window_monitor_core_defines.svh
// assertion macros for the mltl window monitor checker
// expects clk and arst_n in the scope of each use
`ifndef MLTL_WINDOW_MONITOR_CORE_DEFINES_SVH
`define MLTL_WINDOW_MONITOR_CORE_DEFINES_SVH

// plain property under the block clock, off during reset
`define MWM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// signal holds its value across a stalled handshake
`define MWM_ASSERT_STALL(lbl, vld, rdy, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

### hw/rtl/mwm_pkg.sv
// shared types and constants of the mltl window monitor
// no dependencies
`timescale 1ns / 1ps

package mwm_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ALWAYS_WINDOW     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EVENTUALLY_WINDOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UNTIL_WINDOW      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_WINDOW    = 2'd3;

	// verdict codes
	localparam logic [1:0] VERDICT_FALSE   = 2'd0;
	localparam logic [1:0] VERDICT_TRUE    = 2'd1;
	localparam logic [1:0] VERDICT_PENDING = 2'd2;
	localparam logic [1:0] VERDICT_RSVD    = 2'd3;

	typedef struct packed {
		logic always_sample;
		logic eventually_sample;
		logic until_hold;
		logic until_goal;
		logic release_trigger;
		logic release_hold;
	} sample_t;

	typedef struct packed {
		logic [1:0] always_verdict;
		logic [1:0] eventually_verdict;
		logic [1:0] until_verdict;
		logic [1:0] release_verdict;
	} verdict_t;

	// controller to datapath
	typedef struct packed {
		logic start;     // item accepted: store samples, arm scan
		logic rd_issue;  // read one history row, newest first
		logic load_out;  // capture verdicts into output register
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_rd;   // current read is the oldest row needed
	} ctrl_sts_t;

endpackage

### hw/rtl/mwm_in_if.sv
// input channel of the mltl window monitor: one tick of six propositions
// no dependencies
`timescale 1ns / 1ps

interface mwm_in_if;
	logic valid;
	logic ready;
	logic always_sample;
	logic eventually_sample;
	logic until_hold;
	logic until_goal;
	logic release_trigger;
	logic release_hold;

	modport source (
		output valid, always_sample, eventually_sample, until_hold, until_goal,
		       release_trigger, release_hold,
		input  ready
	);
	modport sink (
		input  valid, always_sample, eventually_sample, until_hold, until_goal,
		       release_trigger, release_hold,
		output ready
	);
endinterface

### hw/rtl/mwm_out_if.sv
// output channel of the mltl window monitor: four verdicts per item
// no dependencies
`timescale 1ns / 1ps

interface mwm_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] always_verdict;
	logic [1:0] eventually_verdict;
	logic [1:0] until_verdict;
	logic [1:0] release_verdict;

	modport source (
		output valid, always_verdict, eventually_verdict, until_verdict, release_verdict,
		input  ready
	);
	modport sink (
		input  valid, always_verdict, eventually_verdict, until_verdict, release_verdict,
		output ready
	);
endinterface

### hw/rtl/mwm_ctrl.sv
// controller of the mltl window monitor: accept, scan, drain, deliver
// depends on mwm_pkg
`timescale 1ns / 1ps

module mwm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output mwm_pkg::ctrl_cmd_t cmd,
	input  mwm_pkg::ctrl_sts_t sts
);
	import mwm_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt    = state_q;
		cmd.start    = 1'b0;
		cmd.rd_issue = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.rd_issue = 1'b1;
				if (sts.last_rd) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

### hw/rtl/mwm_dpath.sv
// datapath of the mltl window monitor: window registers, history memory,
// backward scan accumulators and output register; depends on mwm_pkg
`timescale 1ns / 1ps

module mwm_dpath #(
	parameter int WINDOW_MAX = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mwm_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [mwm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  mwm_pkg::sample_t                 sample,
	input  mwm_pkg::ctrl_cmd_t               cmd,
	output mwm_pkg::ctrl_sts_t               sts,
	output mwm_pkg::verdict_t                verdict
);
	import mwm_pkg::*;

	localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int EW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;

	logic [CFG_DATA_W-1:0] always_win_q;
	logic [CFG_DATA_W-1:0] eventually_win_q;
	logic [CFG_DATA_W-1:0] until_win_q;
	logic [CFG_DATA_W-1:0] release_win_q;

	logic [CW-1:0] n_alw, n_evt, n_unt, n_rel, n_max01, n_max23, n_max;

	sample_t       mem [WINDOW_MAX];
	sample_t       data_s1;
	logic          valid_s1;
	logic [CW-1:0] age_s1;

	logic [AW-1:0] wp_q;
	logic [AW-1:0] rd_addr_q;
	logic [CW-1:0] age_q;
	logic [CW-1:0] seen_q;

	logic alw_q, evt_q, unt_q, rel_q;
	verdict_t verdict_q;

	// zero reads as one, anything above the history depth saturates
	function automatic logic [CW-1:0] eff_window(input logic [CFG_DATA_W-1:0] r);
		logic [EW-1:0] ext;
		ext = EW'(r);
		if (r == '0) return CW'(1);
		else if (ext > EW'(WINDOW_MAX)) return CW'(WINDOW_MAX);
		else return CW'(ext);
	endfunction

	assign n_alw   = eff_window(always_win_q);
	assign n_evt   = eff_window(eventually_win_q);
	assign n_unt   = eff_window(until_win_q);
	assign n_rel   = eff_window(release_win_q);
	assign n_max01 = (n_alw > n_evt) ? n_alw : n_evt;
	assign n_max23 = (n_unt > n_rel) ? n_unt : n_rel;
	assign n_max   = (n_max01 > n_max23) ? n_max01 : n_max23;

	assign sts.last_rd = (age_q == (n_max - CW'(1)));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			always_win_q     <= CFG_DATA_W'(1);
			eventually_win_q <= CFG_DATA_W'(1);
			until_win_q      <= CFG_DATA_W'(1);
			release_win_q    <= CFG_DATA_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_ALWAYS_WINDOW:     always_win_q     <= cfg_data;
				CFG_EVENTUALLY_WINDOW: eventually_win_q <= cfg_data;
				CFG_UNTIL_WINDOW:      until_win_q      <= cfg_data;
				CFG_RELEASE_WINDOW:    release_win_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// history memory: one write per item, one registered read per scan step
	always_ff @(posedge clk) begin
		if (cmd.start) mem[wp_q] <= sample;
		if (cmd.rd_issue) begin
			data_s1 <= mem[rd_addr_q];
			age_s1  <= age_q;
		end
	end

	// pointers, counters and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			rd_addr_q <= '0;
			age_q     <= '0;
			seen_q    <= '0;
			valid_s1  <= 1'b0;
			alw_q     <= 1'b1;
			evt_q     <= 1'b0;
			unt_q     <= 1'b0;
			rel_q     <= 1'b1;
		end else begin
			valid_s1 <= cmd.rd_issue;
			if (cmd.start) begin
				wp_q      <= (wp_q == AW'(WINDOW_MAX - 1)) ? '0 : wp_q + AW'(1);
				if (seen_q != CW'(WINDOW_MAX)) seen_q <= seen_q + CW'(1);
				rd_addr_q <= wp_q;
				age_q     <= '0;
				alw_q     <= 1'b1;
				evt_q     <= 1'b0;
				unt_q     <= 1'b0;
				rel_q     <= 1'b1;
			end else begin
				if (cmd.rd_issue) begin
					age_q     <= age_q + CW'(1);
					rd_addr_q <= (rd_addr_q == '0) ? AW'(WINDOW_MAX - 1)
					                               : rd_addr_q - AW'(1);
				end
				// rows arrive newest first, so an older decisive tick overrides
				if (valid_s1) begin
					if (age_s1 < n_alw && !data_s1.always_sample) alw_q <= 1'b0;
					if (age_s1 < n_evt && data_s1.eventually_sample) evt_q <= 1'b1;
					if (age_s1 < n_unt) begin
						if (data_s1.until_goal) unt_q <= 1'b1;
						else if (!data_s1.until_hold) unt_q <= 1'b0;
					end
					if (age_s1 < n_rel) begin
						if (!data_s1.release_hold) rel_q <= 1'b0;
						else if (data_s1.release_trigger) rel_q <= 1'b1;
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			verdict_q.always_verdict     <= (seen_q < n_alw) ? VERDICT_PENDING :
			                                alw_q ? VERDICT_TRUE : VERDICT_FALSE;
			verdict_q.eventually_verdict <= (seen_q < n_evt) ? VERDICT_PENDING :
			                                evt_q ? VERDICT_TRUE : VERDICT_FALSE;
			verdict_q.until_verdict      <= (seen_q < n_unt) ? VERDICT_PENDING :
			                                unt_q ? VERDICT_TRUE : VERDICT_FALSE;
			verdict_q.release_verdict    <= (seen_q < n_rel) ? VERDICT_PENDING :
			                                rel_q ? VERDICT_TRUE : VERDICT_FALSE;
		end
	end

	assign verdict = verdict_q;

endmodule

### hw/rtl/mltl_window_monitor_core.sv
// Bounded-future MLTL runtime monitor over sliding windows. Each input item is
// one tick of six proposition bits; each tick gives one result item of four
// verdicts (globally, finally, until, release), coded false, true or pending.
// An item is accepted only in the idle state: the block takes no new item until
// the result of the last one is loaded into the output register, which waits for
// the output to be free. The scan covers max(N) past ticks, where max(N) is the
// largest of the four effective window lengths (1 to WINDOW_MAX): the single read
// port of the history memory delivers one past tick per cycle, newest first. A
// finished result sits in the output register while the next item is accepted.
// Window registers are 7 bits, zero acts as 1, values above WINDOW_MAX saturate.
// Depends on mwm_pkg, mwm_in_if, mwm_out_if, mwm_ctrl and mwm_dpath.
`timescale 1ns / 1ps

module mltl_window_monitor_core #(
	parameter int WINDOW_MAX = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port, one register per index
	input  logic                           cfg_we,
	input  logic [mwm_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [mwm_pkg::CFG_DATA_W-1:0] cfg_data,
	// tick items in, verdict items out
	mwm_in_if.sink                         in_ch,
	mwm_out_if.source                      out_ch
);
	import mwm_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;
	sample_t   sample;
	verdict_t  verdict;

	// pack the tick fields for the history memory
	assign sample.always_sample     = in_ch.always_sample;
	assign sample.eventually_sample = in_ch.eventually_sample;
	assign sample.until_hold        = in_ch.until_hold;
	assign sample.until_goal        = in_ch.until_goal;
	assign sample.release_trigger   = in_ch.release_trigger;
	assign sample.release_hold      = in_ch.release_hold;

	// sequencer: idle, scan the history, drain the read register, deliver
	mwm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// window registers, history, verdict accumulators and output register
	mwm_dpath #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.sample   (sample),
		.cmd      (cmd),
		.sts      (sts),
		.verdict  (verdict)
	);

	// result fields straight from the output register
	assign out_ch.always_verdict     = verdict.always_verdict;
	assign out_ch.eventually_verdict = verdict.eventually_verdict;
	assign out_ch.until_verdict      = verdict.until_verdict;
	assign out_ch.release_verdict    = verdict.release_verdict;

endmodule

### hw/rtl/mwm_checker.sv
// port-level checks of the mltl window monitor, bound to the top level
// depends on mwm_pkg and mltl_window_monitor_core_defines.svh
`timescale 1ns / 1ps
`include "mltl_window_monitor_core_defines.svh"

module mwm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] always_verdict,
	input logic [1:0] eventually_verdict,
	input logic [1:0] until_verdict,
	input logic [1:0] release_verdict
);
	import mwm_pkg::*;

	logic [7:0] out_payload;
	logic       verdict_bad;

	assign out_payload = {always_verdict, eventually_verdict, until_verdict, release_verdict};
	assign verdict_bad = (always_verdict == VERDICT_RSVD) || (eventually_verdict == VERDICT_RSVD)
	                  || (until_verdict == VERDICT_RSVD) || (release_verdict == VERDICT_RSVD);

	`MWM_ASSERT_STALL(a_out_valid_holds, out_valid, out_ready, out_valid, "out valid dropped")
	`MWM_ASSERT_STALL(a_out_data_holds, out_valid, out_ready, out_payload, "out item changed")
	`MWM_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "ready after accept")
	`MWM_ASSERT(a_verdict_code, out_valid |-> !verdict_bad, "reserved verdict code")

endmodule

bind mltl_window_monitor_core mwm_checker u_mwm_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (in_ch.valid),
	.in_ready           (in_ch.ready),
	.out_valid          (out_ch.valid),
	.out_ready          (out_ch.ready),
	.always_verdict     (out_ch.always_verdict),
	.eventually_verdict (out_ch.eventually_verdict),
	.until_verdict      (out_ch.until_verdict),
	.release_verdict    (out_ch.release_verdict)
);

### test/tb.sv
// testbench for the mltl window monitor: directed and biased random ticks against a verdict predictor
// depends on mwm_pkg, mwm_in_if, mwm_out_if and mltl_window_monitor_core
`timescale 1ns / 1ps

import mwm_pkg::*;

localparam int MON_DEPTH = 64;

// predicts the four verdicts of every accepted tick and checks the results in order
class verdict_board;
	sample_t               ring [MON_DEPTH];
	int unsigned           wr_ptr;
	int unsigned           seen;
	logic [CFG_DATA_W-1:0] win [4];
	verdict_t              verdicts_due [$];
	int                    miscount;

	function new();
		wr_ptr = 0;
		seen = 0;
		miscount = 0;
		foreach (win[i]) win[i] = 1;
		foreach (ring[i]) ring[i] = '0;
	endfunction

	function void set_window(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		win[idx] = val;
	endfunction

	// scan one operator's window from the oldest tick
	function logic [1:0] judge(logic [CFG_IDX_W-1:0] op);
		int unsigned n;
		int unsigned k;
		sample_t t;
		n = (win[op] == 0) ? 1 : ((win[op] > MON_DEPTH) ? MON_DEPTH : win[op]);
		if (seen < n)
			return VERDICT_PENDING;
		for (k = 0; k < n; k++) begin
			t = ring[(wr_ptr + MON_DEPTH - n + k) % MON_DEPTH];
			case (op)
				CFG_ALWAYS_WINDOW: begin
					if (!t.always_sample) return VERDICT_FALSE;
				end
				CFG_EVENTUALLY_WINDOW: begin
					if (t.eventually_sample) return VERDICT_TRUE;
				end
				CFG_UNTIL_WINDOW: begin
					if (t.until_goal) return VERDICT_TRUE;
					if (!t.until_hold) return VERDICT_FALSE;
				end
				default: begin
					if (!t.release_hold) return VERDICT_FALSE;
					if (t.release_trigger) return VERDICT_TRUE;
				end
			endcase
		end
		return (op == CFG_ALWAYS_WINDOW || op == CFG_RELEASE_WINDOW) ? VERDICT_TRUE
		                                                             : VERDICT_FALSE;
	endfunction

	function void note_tick(sample_t s);
		verdict_t v;
		ring[wr_ptr] = s;
		wr_ptr = (wr_ptr + 1) % MON_DEPTH;
		if (seen < MON_DEPTH)
			seen++;
		v.always_verdict     = judge(CFG_ALWAYS_WINDOW);
		v.eventually_verdict = judge(CFG_EVENTUALLY_WINDOW);
		v.until_verdict      = judge(CFG_UNTIL_WINDOW);
		v.release_verdict    = judge(CFG_RELEASE_WINDOW);
		verdicts_due.push_back(v);
	endfunction

	function void check_verdict(verdict_t got);
		verdict_t want;
		string    fname [4];
		fname = '{"always", "eventually", "until", "release"};
		if (verdicts_due.size() == 0) begin
			$display("%0t: verdict item with none outstanding: %h", $time, got);
			miscount++;
			return;
		end
		want = verdicts_due.pop_front();
		for (int f = 0; f < 4; f++) begin
			if (got[(3 - f) * 2 +: 2] !== want[(3 - f) * 2 +: 2]) begin
				$display("%0t: %s verdict mismatch: expected %0d, actual %0d", $time,
				         fname[f], want[(3 - f) * 2 +: 2], got[(3 - f) * 2 +: 2]);
				miscount++;
			end
		end
	endfunction

	function int outstanding();
		return verdicts_due.size();
	endfunction
endclass

module tb;
	localparam int RANDOM_ITEMS = 800;
	localparam int QUIET_FROM   = 700;       // no idling past this many random items
	localparam int CYCLE_LIMIT  = 400000;    // run limit, far above the slowest run

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	bit                    quiet;
	int                    cycles;
	int                    random_sent;
	int                    phase_len;
	int                    pct [6];
	int                    pick;
	verdict_board          sb;

	mwm_in_if  in_ch ();
	mwm_out_if out_ch ();

	mltl_window_monitor_core #(
		.WINDOW_MAX(MON_DEPTH)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	// 10 ns clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit, counts every rising edge
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: run limit reached, %0d verdicts outstanding", $time, sb.outstanding());
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side: check every accepted verdict item against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			sb.check_verdict('{out_ch.always_verdict, out_ch.eventually_verdict,
			                   out_ch.until_verdict, out_ch.release_verdict});
		end
	end

	// result side back-pressure: random stall bursts, none once the run goes quiet
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	// biased coin, percent chance of a one
	function automatic bit coin(int p);
		return $urandom_range(0, 99) < p;
	endfunction

	// mostly short windows, sometimes the full depth, zero or an oversized value
	function automatic logic [CFG_DATA_W-1:0] pick_window();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return '0;
		if (r == 1) return CFG_DATA_W'(MON_DEPTH);
		if (r == 2) return CFG_DATA_W'($urandom_range(MON_DEPTH + 1, 127));
		if (r <= 4) return CFG_DATA_W'($urandom_range(9, MON_DEPTH - 1));
		return CFG_DATA_W'($urandom_range(1, 8));
	endfunction

	// one tick item: optional gap, then hold valid until accepted; returns at a falling edge
	task automatic send_tick(input sample_t s);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_ch.valid             <= 1'b1;
		in_ch.always_sample     <= s.always_sample;
		in_ch.eventually_sample <= s.eventually_sample;
		in_ch.until_hold        <= s.until_hold;
		in_ch.until_goal        <= s.until_goal;
		in_ch.release_trigger   <= s.release_trigger;
		in_ch.release_hold      <= s.release_hold;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sb.note_tick(s);
		@(negedge clk);
	endtask

	// stop sending and wait for every predicted verdict to come back
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.outstanding() > 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// write all four window registers on consecutive cycles, block must be idle
	task automatic write_windows(input logic [CFG_DATA_W-1:0] w_a, input logic [CFG_DATA_W-1:0] w_e,
	                             input logic [CFG_DATA_W-1:0] w_u, input logic [CFG_DATA_W-1:0] w_r);
		logic [CFG_IDX_W-1:0]  idx_list [4];
		logic [CFG_DATA_W-1:0] val_list [4];
		idx_list = '{CFG_ALWAYS_WINDOW, CFG_EVENTUALLY_WINDOW, CFG_UNTIL_WINDOW, CFG_RELEASE_WINDOW};
		val_list = '{w_a, w_e, w_u, w_r};
		for (int i = 0; i < 4; i++) begin
			cfg_we   <= 1'b1;
			cfg_idx  <= idx_list[i];
			cfg_data <= val_list[i];
			@(negedge clk);
			sb.set_window(idx_list[i], val_list[i]);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		sb = new();
		// every input known from time zero
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		quiet = 1'b0;
		random_sent = 0;
		in_ch.valid = 1'b0;
		in_ch.always_sample = 1'b0;
		in_ch.eventually_sample = 1'b0;
		in_ch.until_hold = 1'b0;
		in_ch.until_goal = 1'b0;
		in_ch.release_trigger = 1'b0;
		in_ch.release_hold = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// tick bits below, msb first: always, eventually, until hold, until goal,
		// release trigger, release hold

		// reset windows of one tick: every operator decided on the current tick alone
		send_tick(sample_t'(6'b000000));   // until no hold no goal, release hold low
		send_tick(sample_t'(6'b111111));
		send_tick(sample_t'(6'b101001));   // until undecided, release never triggered
		send_tick(sample_t'(6'b010110));   // goal without hold, trigger without hold
		drain();

		// zero registers act as a window of one
		write_windows('0, '0, '0, '0);
		send_tick(sample_t'(6'b101011));   // release trigger with hold
		send_tick(sample_t'(6'b010100));
		drain();

		// full and oversized windows: pending until the window fills
		write_windows(CFG_DATA_W'(MON_DEPTH), 127, CFG_DATA_W'(MON_DEPTH + 1),
		              CFG_DATA_W'(MON_DEPTH));
		repeat (5) send_tick(sample_t'(6'b111001));
		send_tick(sample_t'(6'b101101));
		repeat (4) send_tick(sample_t'(6'b100001));
		drain();

		// shrink windows while running: enough ticks already held, decided at once
		write_windows(3, 5, 4, 2);
		send_tick(sample_t'(6'b001001));
		send_tick(sample_t'(6'b101011));
		send_tick(sample_t'(6'b110000));
		send_tick(sample_t'(6'b001111));
		send_tick(sample_t'(6'b011001));
		send_tick(sample_t'(6'b100000));
		drain();

		// random phases: first one at full depth so the fill from pending is crossed
		write_windows(CFG_DATA_W'(MON_DEPTH), CFG_DATA_W'(MON_DEPTH), CFG_DATA_W'(MON_DEPTH),
		              CFG_DATA_W'(MON_DEPTH));
		pick = 0;
		while (random_sent < RANDOM_ITEMS) begin
			if (pick > 0)
				write_windows(pick_window(), pick_window(), pick_window(), pick_window());
			pick++;
			// per-phase bias per bit: long hold runs with rare goals and triggers,
			// mostly-one or mostly-zero streams, or plain noise
			foreach (pct[i]) begin
				case ($urandom_range(0, 4))
					0: pct[i] = 3;
					1: pct[i] = 25;
					2: pct[i] = 50;
					3: pct[i] = 75;
					default: pct[i] = 97;
				endcase
			end
			phase_len = $urandom_range(20, 90);
			for (int j = 0; j < phase_len && random_sent < RANDOM_ITEMS; j++) begin
				if (random_sent >= QUIET_FROM)
					quiet = 1'b1;
				send_tick('{coin(pct[0]), coin(pct[1]), coin(pct[2]),
				            coin(pct[3]), coin(pct[4]), coin(pct[5])});
				random_sent++;
			end
			drain();
		end

		// settle for one worst-case item latency, then judge
		repeat (MON_DEPTH + 8) @(negedge clk);
		if (sb.outstanding() > 0)
			$display("%0t: %0d predicted verdicts never arrived", $time, sb.outstanding());
		if (sb.miscount == 0 && sb.outstanding() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
